/* hw/rtl/hbs_pkg.sv */
package hbs_pkg;

	localparam int GRID_COLS_MAX = 256;
	localparam int GRID_ROWS_MAX = 256;

	localparam int POS_W = 24;
	localparam int EXT_W = 23;
	localparam int CPU_W = 24;
	localparam int SIZE_W = 9;
	localparam int CELL_W = 8;
	localparam int HGT_W = 8;
	localparam int FRAC_W = 8;
	localparam int RES_W = 16;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 24;

	localparam int PROD_W = EXT_W + CPU_W;
	localparam int SCALE_SH = 16;
	localparam int G_W = PROD_W - SCALE_SH;
	localparam int INT_W = G_W - FRAC_W;

	localparam int COL_W = (GRID_COLS_MAX > 1) ? $clog2(GRID_COLS_MAX) : 1;
	localparam int ROW_W = (GRID_ROWS_MAX > 1) ? $clog2(GRID_ROWS_MAX) : 1;
	localparam int COLS_CNT_W = $clog2(GRID_COLS_MAX + 1);
	localparam int ROWS_CNT_W = $clog2(GRID_ROWS_MAX + 1);

	localparam int NUM_BANKS = 4;
	localparam int BANK_COLS = (GRID_COLS_MAX + 1) / 2;
	localparam int BANK_ROWS = (GRID_ROWS_MAX + 1) / 2;
	localparam int BANK_DEPTH = BANK_COLS * BANK_ROWS;
	localparam int BCOL_W = (BANK_COLS > 1) ? $clog2(BANK_COLS) : 1;
	localparam int BROW_W = (BANK_ROWS > 1) ? $clog2(BANK_ROWS) : 1;
	localparam int BANK_AW = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

	typedef enum logic {
		KIND_WRITE  = 1'b0,
		KIND_SAMPLE = 1'b1
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ORIGIN_X    = 3'd0,
		REG_ORIGIN_Z    = 3'd1,
		REG_EXTENT_X    = 3'd2,
		REG_EXTENT_Z    = 3'd3,
		REG_CPU_X       = 3'd4,
		REG_CPU_Z       = 3'd5,
		REG_GRID_WIDTH  = 3'd6,
		REG_GRID_HEIGHT = 3'd7
	} cfg_idx_t;

	typedef struct packed {
		logic              kind;
		logic [CELL_W-1:0] cell_col;
		logic [CELL_W-1:0] cell_row;
		logic [HGT_W-1:0]  cell_height;
		logic [POS_W-1:0]  pos_x;
		logic [POS_W-1:0]  pos_z;
	} item_t;

	typedef struct packed {
		logic [POS_W-1:0]      origin_x;
		logic [POS_W-1:0]      origin_z;
		logic [EXT_W-1:0]      extent_x;
		logic [EXT_W-1:0]      extent_z;
		logic [CPU_W-1:0]      cpu_x;
		logic [CPU_W-1:0]      cpu_z;
		logic [COLS_CNT_W-1:0] cols;
		logic [ROWS_CNT_W-1:0] rows;
	} cfg_t;

	typedef struct packed {
		logic              vld;
		logic              in_rect;
		logic [FRAC_W-1:0] fx;
		logic [FRAC_W-1:0] fz;
		logic              x_odd;
		logic              z_odd;
		logic              next_x;
		logic              next_z;
	} look_t;

	typedef struct packed {
		logic [NUM_BANKS-1:0] we;
		logic [BANK_AW-1:0]   addr;
		logic [HGT_W-1:0]     data;
	} wr_t;

	typedef struct packed {
		logic [RES_W-1:0] height;
		logic             inside_res;
	} res_t;

	function automatic logic [COLS_CNT_W-1:0] clamp_cols(input logic [SIZE_W-1:0] v);
		logic [COLS_CNT_W-1:0] r;
		if (v == '0) begin
			r = COLS_CNT_W'(1);
		end else if (int'(v) > GRID_COLS_MAX) begin
			r = COLS_CNT_W'(GRID_COLS_MAX);
		end else begin
			r = COLS_CNT_W'(v);
		end
		return r;
	endfunction

	function automatic logic [ROWS_CNT_W-1:0] clamp_rows(input logic [SIZE_W-1:0] v);
		logic [ROWS_CNT_W-1:0] r;
		if (v == '0) begin
			r = ROWS_CNT_W'(1);
		end else if (int'(v) > GRID_ROWS_MAX) begin
			r = ROWS_CNT_W'(GRID_ROWS_MAX);
		end else begin
			r = ROWS_CNT_W'(v);
		end
		return r;
	endfunction

endpackage

/* hw/rtl/hbs_req_if.sv */
interface hbs_req_if;
	import hbs_pkg::*;

	logic                     valid;
	logic                     ready;
	logic                     kind;
	logic [CELL_W-1:0]        cell_col;
	logic [CELL_W-1:0]        cell_row;
	logic [HGT_W-1:0]         cell_height;
	logic signed [POS_W-1:0]  pos_x;
	logic signed [POS_W-1:0]  pos_z;

	modport source (output valid, kind, cell_col, cell_row, cell_height, pos_x, pos_z,
		input ready);
	modport sink (input valid, kind, cell_col, cell_row, cell_height, pos_x, pos_z,
		output ready);
	modport mon (input valid, ready, kind, cell_col, cell_row, cell_height, pos_x, pos_z);
endinterface

/* hw/rtl/hbs_rsp_if.sv */
interface hbs_rsp_if;
	import hbs_pkg::*;

	logic             valid;
	logic             ready;
	logic [RES_W-1:0] height;
	logic             inside_res;

	modport source (output valid, height, inside_res, input ready);
	modport sink (input valid, height, inside_res, output ready);
	modport mon (input valid, ready, height, inside_res);
endinterface

/* hw/rtl/hbs_cfg_if.sv */
interface hbs_cfg_if;
	import hbs_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  idx;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, idx, data, input ready);
	modport sink (input valid, idx, data, output ready);
	modport mon (input valid, ready, idx, data);
endinterface

/* hw/rtl/hbs_bank_ram.sv */
module hbs_bank_ram #(
	parameter int AW = 14,
	parameter int DW = 8,
	parameter int DEPTH = 16384
) (
	input  logic          clk,
	input  logic          rd_en,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata
);
	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata <= mem[raddr];
		end
	end
endmodule

/* hw/rtl/hbs_coord.sv */
module hbs_coord (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          adv,
	input  logic                                          take,
	input  hbs_pkg::item_t                                item,
	input  hbs_pkg::cfg_t                                 cfg,
	output hbs_pkg::look_t                                look,
	output logic [hbs_pkg::NUM_BANKS-1:0][hbs_pkg::BANK_AW-1:0] rd_addr,
	output hbs_pkg::wr_t                                  wr
);
	import hbs_pkg::*;

	logic              vld_s1;
	item_t             item_s1;

	logic              vld_s2;
	logic              smp_s2;
	logic [CELL_W-1:0] col_s2;
	logic [CELL_W-1:0] row_s2;
	logic [HGT_W-1:0]  hgt_s2;
	logic              inside_s2;
	logic [EXT_W-1:0]  dx_s2;
	logic [EXT_W-1:0]  dz_s2;

	logic              vld_s3;
	logic              smp_s3;
	logic [CELL_W-1:0] col_s3;
	logic [CELL_W-1:0] row_s3;
	logic [HGT_W-1:0]  hgt_s3;
	logic              inside_s3;
	logic [G_W-1:0]    gx_s3;
	logic [G_W-1:0]    gz_s3;

	logic [POS_W:0]    dx;
	logic [POS_W:0]    dz;
	logic              in_x;
	logic              in_z;
	logic [PROD_W-1:0] prod_x;
	logic [PROD_W-1:0] prod_z;

	logic [INT_W-1:0]      ix_raw;
	logic [INT_W-1:0]      iz_raw;
	logic [COL_W-1:0]      ix;
	logic [ROW_W-1:0]      iz;
	logic [COLS_CNT_W-1:0] ix_nx;
	logic [ROWS_CNT_W-1:0] iz_nx;
	logic [BCOL_W-1:0]     col_even;
	logic [BCOL_W-1:0]     col_odd;
	logic [BROW_W-1:0]     row_even;
	logic [BROW_W-1:0]     row_odd;
	logic                  wr_ok;
	logic [1:0]            wr_bank;

	// Range test against the half-open rectangle on both axes.
	always_comb begin
		dx = {item_s1.pos_x[POS_W-1], item_s1.pos_x} - {cfg.origin_x[POS_W-1], cfg.origin_x};
		dz = {item_s1.pos_z[POS_W-1], item_s1.pos_z} - {cfg.origin_z[POS_W-1], cfg.origin_z};
		in_x = !dx[POS_W] && (dx[POS_W-1:0] < POS_W'(cfg.extent_x));
		in_z = !dz[POS_W] && (dz[POS_W-1:0] < POS_W'(cfg.extent_z));
	end

	assign prod_x = PROD_W'(dx_s2) * PROD_W'(cfg.cpu_x);
	assign prod_z = PROD_W'(dz_s2) * PROD_W'(cfg.cpu_z);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= take;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s1   <= item;
			smp_s2    <= (item_s1.kind == KIND_SAMPLE);
			col_s2    <= item_s1.cell_col;
			row_s2    <= item_s1.cell_row;
			hgt_s2    <= item_s1.cell_height;
			inside_s2 <= in_x && in_z;
			dx_s2     <= dx[EXT_W-1:0];
			dz_s2     <= dz[EXT_W-1:0];
			smp_s3    <= smp_s2;
			col_s3    <= col_s2;
			row_s3    <= row_s2;
			hgt_s3    <= hgt_s2;
			inside_s3 <= inside_s2;
			gx_s3     <= prod_x[PROD_W-1:SCALE_SH];
			gz_s3     <= prod_z[PROD_W-1:SCALE_SH];
		end
	end

	// Clamp the integer cell to the used grid and find the bank addresses.
	always_comb begin
		ix_raw = gx_s3[G_W-1:FRAC_W];
		iz_raw = gz_s3[G_W-1:FRAC_W];
		if (ix_raw >= INT_W'(cfg.cols)) begin
			ix = COL_W'(cfg.cols - COLS_CNT_W'(1));
		end else begin
			ix = COL_W'(ix_raw);
		end
		if (iz_raw >= INT_W'(cfg.rows)) begin
			iz = ROW_W'(cfg.rows - ROWS_CNT_W'(1));
		end else begin
			iz = ROW_W'(iz_raw);
		end
		ix_nx = COLS_CNT_W'(ix) + COLS_CNT_W'(1);
		iz_nx = ROWS_CNT_W'(iz) + ROWS_CNT_W'(1);
		col_even = BCOL_W'(ix_nx >> 1);
		col_odd  = BCOL_W'(ix >> 1);
		row_even = BROW_W'(iz_nx >> 1);
		row_odd  = BROW_W'(iz >> 1);

		look.vld     = vld_s3 && smp_s3;
		look.in_rect = inside_s3;
		look.fx      = gx_s3[FRAC_W-1:0];
		look.fz      = gz_s3[FRAC_W-1:0];
		look.x_odd   = ix[0];
		look.z_odd   = iz[0];
		look.next_x  = ix_nx < cfg.cols;
		look.next_z  = iz_nx < cfg.rows;

		for (int b = 0; b < NUM_BANKS; b++) begin
			rd_addr[b] = BANK_AW'(int'(b[1] ? row_odd : row_even) * BANK_COLS
				+ int'(b[0] ? col_odd : col_even));
		end

		wr_ok = (int'(col_s3) < GRID_COLS_MAX) && (int'(row_s3) < GRID_ROWS_MAX);
		wr_bank = {row_s3[0], col_s3[0]};
		wr.addr = BANK_AW'(int'(row_s3[CELL_W-1:1]) * BANK_COLS + int'(col_s3[CELL_W-1:1]));
		wr.data = hgt_s3;
		for (int b = 0; b < NUM_BANKS; b++) begin
			wr.we[b] = adv && vld_s3 && !smp_s3 && wr_ok && (wr_bank == 2'(b));
		end
	end
endmodule

/* hw/rtl/hbs_blend.sv */
module hbs_blend (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       adv,
	input  hbs_pkg::look_t                             look,
	input  logic [hbs_pkg::NUM_BANKS-1:0][hbs_pkg::HGT_W-1:0] rd_data,
	output logic                                       res_vld,
	output hbs_pkg::res_t                              res
);
	import hbs_pkg::*;

	look_t            look_s4;
	logic             vld_s5;
	logic             inside_s5;
	logic [FRAC_W-1:0] fz_s5;
	logic [RES_W-1:0] top_s5;
	logic [RES_W-1:0] bot_s5;

	logic [HGT_W-1:0]  ca;
	logic [HGT_W-1:0]  cb;
	logic [HGT_W-1:0]  cc;
	logic [HGT_W-1:0]  cd;
	logic [FRAC_W:0]   wx;
	logic [FRAC_W:0]   wz;
	logic [RES_W:0]    top;
	logic [RES_W:0]    bot;
	logic [RES_W+FRAC_W:0] mix;

	// The four corners sit in four different banks picked by cell parity.
	always_comb begin
		ca = rd_data[{look_s4.z_odd, look_s4.x_odd}];
		cb = look_s4.next_x ? rd_data[{look_s4.z_odd, !look_s4.x_odd}] : '0;
		cc = look_s4.next_z ? rd_data[{!look_s4.z_odd, look_s4.x_odd}] : '0;
		cd = (look_s4.next_x && look_s4.next_z)
			? rd_data[{!look_s4.z_odd, !look_s4.x_odd}] : '0;
		wx = (FRAC_W+1)'(1 << FRAC_W) - {1'b0, look_s4.fx};
		top = (RES_W+1)'(ca) * (RES_W+1)'(wx) + (RES_W+1)'(cb) * (RES_W+1)'(look_s4.fx);
		bot = (RES_W+1)'(cc) * (RES_W+1)'(wx) + (RES_W+1)'(cd) * (RES_W+1)'(look_s4.fx);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			look_s4 <= '0;
			vld_s5  <= 1'b0;
		end else if (adv) begin
			look_s4 <= look;
			vld_s5  <= look_s4.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			inside_s5 <= look_s4.in_rect;
			fz_s5     <= look_s4.fz;
			top_s5    <= top[RES_W-1:0];
			bot_s5    <= bot[RES_W-1:0];
		end
	end

	always_comb begin
		wz = (FRAC_W+1)'(1 << FRAC_W) - {1'b0, fz_s5};
		mix = (RES_W+FRAC_W+1)'(top_s5) * (RES_W+FRAC_W+1)'(wz)
			+ (RES_W+FRAC_W+1)'(bot_s5) * (RES_W+FRAC_W+1)'(fz_s5);
		res_vld = vld_s5 && adv;
		res.inside_res = inside_s5;
		res.height = inside_s5 ? mix[RES_W+FRAC_W-1:FRAC_W] : '0;
	end
endmodule

/* hw/rtl/hbs_skid.sv */
module hbs_skid (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  hbs_pkg::res_t push_data,
	output logic          adv,
	hbs_rsp_if.source     rsp
);
	import hbs_pkg::*;

	logic out_vld_q;
	res_t out_q;
	logic skid_vld_q;
	res_t skid_q;
	logic pop;

	assign pop = out_vld_q && rsp.ready;
	assign adv = !skid_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (skid_vld_q) begin
			if (pop) begin
				skid_vld_q <= 1'b0;
			end
		end else if (push) begin
			if (!out_vld_q || pop) begin
				out_vld_q <= 1'b1;
			end else begin
				skid_vld_q <= 1'b1;
			end
		end else if (pop) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_vld_q) begin
			if (pop) begin
				out_q <= skid_q;
			end
		end else if (push) begin
			if (!out_vld_q || pop) begin
				out_q <= push_data;
			end else begin
				skid_q <= push_data;
			end
		end
	end

	assign rsp.valid      = out_vld_q;
	assign rsp.height     = out_q.height;
	assign rsp.inside_res = out_q.inside_res;
endmodule

/* hw/rtl/heightmap_bilinear_sampler_unit.sv */
// Channel  Role    Payload
// req      sink    kind, cell_col, cell_row, cell_height, pos_x, pos_z
// rsp      source  height, inside_res
// cfg      sink    idx, data
//
// One item is taken per cycle while the skid entry is empty; a sample result reaches
// rsp through the coordinate, bank and blend registers, and a write item gives none.
// The grid lives in four single-port-read banks split by cell parity, so the four
// corners of a sample are read in the same cycle, and writes land at that same stage.
// Reset clears the pipeline and presets the registers but leaves the grid, which reads
// undefined until written. req.ready drops only while the output skid entry is full.
module heightmap_bilinear_sampler_unit (
	input logic      clk,
	input logic      arst_n,
	hbs_req_if.sink  req,
	hbs_rsp_if.source rsp,
	hbs_cfg_if.sink  cfg
);
	import hbs_pkg::*;

	cfg_t  cfg_q;
	item_t item;
	look_t look;
	wr_t   wr;
	logic  adv;
	logic  res_vld;
	res_t  res;
	logic [NUM_BANKS-1:0][BANK_AW-1:0] rd_addr;
	logic [NUM_BANKS-1:0][HGT_W-1:0]   rd_data;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.origin_x <= '0;
			cfg_q.origin_z <= '0;
			cfg_q.extent_x <= '0;
			cfg_q.extent_z <= '0;
			cfg_q.cpu_x    <= CPU_W'(65536);
			cfg_q.cpu_z    <= CPU_W'(65536);
			cfg_q.cols     <= clamp_cols(SIZE_W'(256));
			cfg_q.rows     <= clamp_rows(SIZE_W'(256));
		end else if (cfg.valid) begin
			case (cfg.idx)
				REG_ORIGIN_X:    cfg_q.origin_x <= cfg.data[POS_W-1:0];
				REG_ORIGIN_Z:    cfg_q.origin_z <= cfg.data[POS_W-1:0];
				REG_EXTENT_X:    cfg_q.extent_x <= cfg.data[EXT_W-1:0];
				REG_EXTENT_Z:    cfg_q.extent_z <= cfg.data[EXT_W-1:0];
				REG_CPU_X:       cfg_q.cpu_x    <= cfg.data[CPU_W-1:0];
				REG_CPU_Z:       cfg_q.cpu_z    <= cfg.data[CPU_W-1:0];
				REG_GRID_WIDTH:  cfg_q.cols     <= clamp_cols(cfg.data[SIZE_W-1:0]);
				REG_GRID_HEIGHT: cfg_q.rows     <= clamp_rows(cfg.data[SIZE_W-1:0]);
				default: begin
				end
			endcase
		end
	end

	assign req.ready = adv;

	always_comb begin
		item.kind        = req.kind;
		item.cell_col    = req.cell_col;
		item.cell_row    = req.cell_row;
		item.cell_height = req.cell_height;
		item.pos_x       = req.pos_x;
		item.pos_z       = req.pos_z;
	end

	hbs_coord u_coord (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.take    (req.valid),
		.item    (item),
		.cfg     (cfg_q),
		.look    (look),
		.rd_addr (rd_addr),
		.wr      (wr)
	);

	for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
		hbs_bank_ram #(
			.AW    (BANK_AW),
			.DW    (HGT_W),
			.DEPTH (BANK_DEPTH)
		) u_ram (
			.clk   (clk),
			.rd_en (adv),
			.raddr (rd_addr[b]),
			.rdata (rd_data[b]),
			.we    (wr.we[b]),
			.waddr (wr.addr),
			.wdata (wr.data)
		);
	end

	hbs_blend u_blend (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.look    (look),
		.rd_data (rd_data),
		.res_vld (res_vld),
		.res     (res)
	);

	hbs_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_vld),
		.push_data (res),
		.adv       (adv),
		.rsp       (rsp)
	);
endmodule

/* hw/rtl/hbs_checker.sv */
module hbs_checker (
	input logic       clk,
	input logic       arst_n,
	hbs_req_if.sink   req,
	hbs_rsp_if.source rsp
);
	import hbs_pkg::*;

	logic [3:0] pending_q;
	logic       smp_take;
	logic       res_take;

	assign smp_take = req.valid && req.ready && (req.kind == KIND_SAMPLE);
	assign res_take = rsp.valid && rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (smp_take && !res_take) begin
			pending_q <= pending_q + 4'd1;
		end else if (res_take && !smp_take) begin
			pending_q <= pending_q - 4'd1;
		end
	end

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.ready |=> rsp.valid)
		else $error("Result item dropped while stalled.");

	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.ready |=> $stable(rsp.height) && $stable(rsp.inside_res))
		else $error("Result item changed while stalled.");

	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> pending_q != 4'd0)
		else $error("Result item without a pending sample.");

	a_outside_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.inside_res |-> rsp.height == '0)
		else $error("Outside sample gave a nonzero height.");

	a_height_max: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> rsp.height <= RES_W'(65280))
		else $error("Height above the largest blend.");
endmodule

bind heightmap_bilinear_sampler_unit hbs_checker u_hbs_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.req    (req),
	.rsp    (rsp)
);

/* sim/tb_top.sv */
module tb_top;
	import hbs_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int RANDOM_PHASES = 8;
	localparam int ITEMS_PER_PHASE = 234;

	typedef struct {
		logic signed [POS_W-1:0] org_x;
		logic signed [POS_W-1:0] org_z;
		logic [EXT_W-1:0]        ext_x;
		logic [EXT_W-1:0]        ext_z;
		logic [CPU_W-1:0]        cpu_x;
		logic [CPU_W-1:0]        cpu_z;
		logic [SIZE_W-1:0]       cols;
		logic [SIZE_W-1:0]       rows;
	} map_cfg_t;

	typedef struct {
		bit in_rect;
		int ix;
		int iz;
		int fx;
		int fz;
		bit next_x;
		bit next_z;
	} spot_t;

	logic clk;
	logic arst_n;

	hbs_req_if req();
	hbs_rsp_if rsp();
	hbs_cfg_if cfg();

	heightmap_bilinear_sampler_unit i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cfg    (cfg)
	);

	item_t pending_items[$];
	res_t expected_heights[$];
	item_t next_item;
	res_t oldest;
	map_cfg_t live_map;
	logic [HGT_W-1:0] heights [GRID_ROWS_MAX*GRID_COLS_MAX];
	bit cell_planned [GRID_ROWS_MAX*GRID_COLS_MAX];
	int unsigned send_idle_pct;
	int unsigned stall_pct;
	int mismatches;
	int quiet_cycles;

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	function automatic longint used_size(logic [SIZE_W-1:0] v, longint limit);
		if (v == 0) begin
			return 1;
		end
		return (v > limit) ? limit : longint'(v);
	endfunction

	// Maps a world position onto the grid: cell, fraction and which neighbors exist.
	function automatic spot_t locate(map_cfg_t m, logic signed [POS_W-1:0] px,
			logic signed [POS_W-1:0] pz);
		longint ox, oz, x, z, gx, gz, w, h;
		spot_t s;
		s = '{default: 0};
		ox = m.org_x;
		oz = m.org_z;
		x = px;
		z = pz;
		s.in_rect = x >= ox && x < ox + longint'(m.ext_x) &&
			z >= oz && z < oz + longint'(m.ext_z);
		if (s.in_rect) begin
			gx = ((x - ox) * longint'(m.cpu_x)) >> 16;
			gz = ((z - oz) * longint'(m.cpu_z)) >> 16;
			w = used_size(m.cols, GRID_COLS_MAX);
			h = used_size(m.rows, GRID_ROWS_MAX);
			s.fx = int'(gx & 255);
			s.fz = int'(gz & 255);
			s.ix = int'(((gx >> 8) >= w) ? w - 1 : (gx >> 8));
			s.iz = int'(((gz >> 8) >= h) ? h - 1 : (gz >> 8));
			s.next_x = s.ix + 1 < w;
			s.next_z = s.iz + 1 < h;
		end
		return s;
	endfunction

	function automatic longint cell_at(int col, int row);
		return heights[row*GRID_COLS_MAX + col];
	endfunction

	function automatic res_t sample_height(logic signed [POS_W-1:0] px,
			logic signed [POS_W-1:0] pz);
		spot_t s;
		longint a, b, c, d, top, bot;
		res_t r;
		s = locate(live_map, px, pz);
		r = '0;
		if (s.in_rect) begin
			a = cell_at(s.ix, s.iz);
			b = s.next_x ? cell_at(s.ix + 1, s.iz) : 0;
			c = s.next_z ? cell_at(s.ix, s.iz + 1) : 0;
			d = (s.next_x && s.next_z) ? cell_at(s.ix + 1, s.iz + 1) : 0;
			top = a * (256 - s.fx) + b * s.fx;
			bot = c * (256 - s.fx) + d * s.fx;
			r.height = RES_W'((top * (256 - s.fz) + bot * s.fz) >> 8);
			r.inside_res = 1'b1;
		end
		return r;
	endfunction

	function automatic void push_write(int col, int row, int hgt);
		item_t it;
		it.kind = KIND_WRITE;
		it.cell_col = CELL_W'(col);
		it.cell_row = CELL_W'(row);
		it.cell_height = HGT_W'(hgt);
		it.pos_x = POS_W'($urandom);
		it.pos_z = POS_W'($urandom);
		cell_planned[row*GRID_COLS_MAX + col] = 1'b1;
		pending_items.push_back(it);
	endfunction

	function automatic void claim_cell(int col, int row);
		if (!cell_planned[row*GRID_COLS_MAX + col]) begin
			push_write(col, row, $urandom_range(255));
		end
	endfunction

	// Every cell that the sample will blend is written ahead of it.
	function automatic void push_sample(logic signed [POS_W-1:0] px,
			logic signed [POS_W-1:0] pz);
		spot_t s;
		item_t it;
		s = locate(live_map, px, pz);
		if (s.in_rect) begin
			claim_cell(s.ix, s.iz);
			if (s.next_x) begin
				claim_cell(s.ix + 1, s.iz);
			end
			if (s.next_z) begin
				claim_cell(s.ix, s.iz + 1);
			end
			if (s.next_x && s.next_z) begin
				claim_cell(s.ix + 1, s.iz + 1);
			end
		end
		it.kind = KIND_SAMPLE;
		it.cell_col = CELL_W'($urandom);
		it.cell_row = CELL_W'($urandom);
		it.cell_height = HGT_W'($urandom);
		it.pos_x = px;
		it.pos_z = pz;
		pending_items.push_back(it);
	endfunction

	function automatic logic [POS_W-1:0] pick_coord(logic signed [POS_W-1:0] org,
			logic [EXT_W-1:0] ext);
		longint o, e, v;
		int unsigned r;
		o = org;
		e = ext;
		r = $urandom_range(99);
		if (r < 8) begin
			v = $urandom;
		end else if (r < 20) begin
			case ($urandom_range(3))
				0: v = o;
				1: v = o + e - 1;
				2: v = o + e;
				default: v = o - 1;
			endcase
		end else if (r < 28) begin
			v = ($urandom_range(1) != 0) ? o - 1 - $urandom_range(e / 8) : o + e + $urandom_range(e / 8);
		end else if (e == 0) begin
			v = o;
		end else begin
			v = o + $urandom_range(e - 1);
		end
		return POS_W'(v);
	endfunction

	function automatic logic [SIZE_W-1:0] pick_size();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 75) begin
			return SIZE_W'($urandom_range(1, 24));
		end else if (r < 88) begin
			return SIZE_W'($urandom_range(25, 256));
		end else if (r < 94) begin
			return '0;
		end
		return SIZE_W'($urandom_range(257, 511));
	endfunction

	function automatic logic [EXT_W-1:0] pick_extent();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 5) begin
			return '0;
		end else if (r < 15) begin
			return EXT_W'($urandom_range(1, 255));
		end
		return EXT_W'($urandom_range(256, 64 * 256));
	endfunction

	// Scale spans roughly the used grid, a little over or under, or is random one time in ten.
	function automatic logic [CPU_W-1:0] pick_scale(logic [EXT_W-1:0] ext, longint cells);
		longint k;
		k = (cells << 24) / ((ext == 0) ? 1 : longint'(ext));
		k = k * $urandom_range(85, 125) / 100;
		if (k > 24'hFFFFFF) begin
			k = 24'hFFFFFF;
		end
		if ($urandom_range(9) == 0) begin
			k = $urandom_range(24'hFFFFFF);
		end
		return CPU_W'(k);
	endfunction

	function automatic map_cfg_t random_map();
		map_cfg_t m;
		m.org_x = POS_W'(int'($urandom_range(65535)) - 32768);
		m.org_z = POS_W'(int'($urandom_range(65535)) - 32768);
		m.ext_x = pick_extent();
		m.ext_z = pick_extent();
		m.cols = pick_size();
		m.rows = pick_size();
		m.cpu_x = pick_scale(m.ext_x, used_size(m.cols, GRID_COLS_MAX));
		m.cpu_z = pick_scale(m.ext_z, used_size(m.rows, GRID_ROWS_MAX));
		return m;
	endfunction

	task automatic put_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg.valid <= 1'b1;
		cfg.idx <= idx;
		cfg.data <= val;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
	endtask

	// The closing wait lets the monitor take the last register before items are planned.
	task automatic load_map(map_cfg_t m);
		put_reg(REG_ORIGIN_X, m.org_x);
		put_reg(REG_ORIGIN_Z, m.org_z);
		put_reg(REG_EXTENT_X, CFG_DATA_W'(m.ext_x));
		put_reg(REG_EXTENT_Z, CFG_DATA_W'(m.ext_z));
		put_reg(REG_CPU_X, m.cpu_x);
		put_reg(REG_CPU_Z, m.cpu_z);
		put_reg(REG_GRID_WIDTH, CFG_DATA_W'(m.cols));
		put_reg(REG_GRID_HEIGHT, CFG_DATA_W'(m.rows));
		@(posedge clk);
	endtask

	// Holds off until every queued item has gone in and every sample has answered.
	task automatic drain();
		do @(posedge clk);
		while (pending_items.size() != 0 || req.valid || expected_heights.size() != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_pace(int phase);
		case (phase % 4)
			0: begin send_idle_pct = 0; stall_pct = 0; end
			1: begin send_idle_pct = 69; stall_pct = 0; end
			2: begin send_idle_pct = 0; stall_pct = 69; end
			default: begin send_idle_pct = 32; stall_pct = 32; end
		endcase
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
		end else if (!req.valid || req.ready) begin
			if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				next_item = pending_items.pop_front();
				req.valid <= 1'b1;
				req.kind <= next_item.kind;
				req.cell_col <= next_item.cell_col;
				req.cell_row <= next_item.cell_row;
				req.cell_height <= next_item.cell_height;
				req.pos_x <= next_item.pos_x;
				req.pos_z <= next_item.pos_z;
			end else begin
				req.valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		rsp.ready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.idx)
					REG_ORIGIN_X: live_map.org_x = cfg.data;
					REG_ORIGIN_Z: live_map.org_z = cfg.data;
					REG_EXTENT_X: live_map.ext_x = cfg.data[EXT_W-1:0];
					REG_EXTENT_Z: live_map.ext_z = cfg.data[EXT_W-1:0];
					REG_CPU_X: live_map.cpu_x = cfg.data;
					REG_CPU_Z: live_map.cpu_z = cfg.data;
					REG_GRID_WIDTH: live_map.cols = cfg.data[SIZE_W-1:0];
					REG_GRID_HEIGHT: live_map.rows = cfg.data[SIZE_W-1:0];
					default: ;
				endcase
			end
			if (req.valid && req.ready) begin
				if (req.kind == KIND_WRITE) begin
					heights[int'(req.cell_row)*GRID_COLS_MAX + int'(req.cell_col)] = req.cell_height;
				end else begin
					expected_heights.push_back(sample_height(req.pos_x, req.pos_z));
				end
			end
			if (rsp.valid && rsp.ready) begin
				if (expected_heights.size() == 0) begin
					$error("unexpected result: height %0d, inside_res %0b", rsp.height,
						rsp.inside_res);
					mismatches++;
				end else begin
					oldest = expected_heights.pop_front();
					if (rsp.height !== oldest.height) begin
						$error("height: expected %0d, got %0d", oldest.height, rsp.height);
						mismatches++;
					end
					if (rsp.inside_res !== oldest.inside_res) begin
						$error("inside_res: expected %0b, got %0b", oldest.inside_res,
							rsp.inside_res);
						mismatches++;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req.valid && req.ready) || (rsp.valid && rsp.ready) ||
				(cfg.valid && cfg.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.kind = KIND_WRITE;
		req.cell_col = '0;
		req.cell_row = '0;
		req.cell_height = '0;
		req.pos_x = '0;
		req.pos_z = '0;
		rsp.ready = 1'b1;
		cfg.valid = 1'b0;
		cfg.idx = REG_ORIGIN_X;
		cfg.data = '0;
		mismatches = 0;
		quiet_cycles = 0;
		live_map = '{org_x: 0, org_z: 0, ext_x: 0, ext_z: 0, cpu_x: 65536, cpu_z: 65536,
			cols: 256, rows: 256};
		set_pace(0);
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// With the reset extents every position lies outside.
		push_sample(0, 0);
		push_sample(24'h7FFFFF, 24'h800000);
		push_write(255, 255, 255);
		push_write(0, 0, 0);
		push_write(170, 85, 8'hAA);
		push_write(85, 170, 8'h55);
		drain();

		load_map('{org_x: -512, org_z: 256, ext_x: 2048, ext_z: 2048, cpu_x: 65536,
			cpu_z: 65536, cols: 8, rows: 8});
		push_write(0, 0, 255);
		push_write(1, 0, 255);
		push_write(0, 1, 255);
		push_write(1, 1, 255);
		push_sample(-512, 256);
		push_sample(-512 + 2047, 256 + 2047);
		push_sample(-513, 256);
		push_sample(-512 + 2048, 256);
		push_sample(-512, 255);
		push_sample(-512, 256 + 2048);
		push_sample(-512 + 3*256 + 128, 256 + 2*256 + 64);
		drain();

		// Widest rectangle, largest scale, oversized and zero grid sizes.
		load_map('{org_x: -8388608, org_z: -8388608, ext_x: 8388607, ext_z: 8388607,
			cpu_x: 24'hFFFFFF, cpu_z: 24'hFFFFFF, cols: 511, rows: 0});
		push_sample(-8388608, -8388608);
		push_sample(8388606, 8388606);
		push_sample(8388607, 0);
		push_sample(0, -8388608);
		drain();

		load_map('{org_x: 8388607, org_z: 8388607, ext_x: 8388607, ext_z: 8388607,
			cpu_x: 0, cpu_z: 0, cols: 1, rows: 257});
		push_sample(8388607, 8388607);
		push_sample(8388606, 8388607);
		drain();

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			load_map(random_map());
			set_pace(p);
			while (pending_items.size() < ITEMS_PER_PHASE) begin
				if ($urandom_range(99) < 30) begin
					push_write($urandom_range(255), $urandom_range(255), $urandom_range(255));
				end else begin
					push_sample(pick_coord(live_map.org_x, live_map.ext_x),
						pick_coord(live_map.org_z, live_map.ext_z));
				end
			end
			drain();
		end

		if (mismatches == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

/* sim.f */
hw/rtl/hbs_pkg.sv
hw/rtl/hbs_req_if.sv
hw/rtl/hbs_rsp_if.sv
hw/rtl/hbs_cfg_if.sv
hw/rtl/hbs_bank_ram.sv
hw/rtl/hbs_coord.sv
hw/rtl/hbs_blend.sv
hw/rtl/hbs_skid.sv
hw/rtl/heightmap_bilinear_sampler_unit.sv
hw/rtl/hbs_checker.sv
sim/tb_top.sv
